// ===== design/sorted_set_engine_macros.svh =====
// Assertion macros for the sorted set engine checker.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef SORTED_SET_ENGINE_MACROS_SVH
`define SORTED_SET_ENGINE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SSE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted set engine assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define SSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted set engine assertion failed");

`endif

// ===== design/sse_pkg.sv =====
// Shared types and constants for the sorted set engine.
// Used by the cell, the top level and the checker; depends on nothing.
package sse_pkg;

    localparam int SSE_CAPACITY = 32;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_MEMBER = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOCHANGE = 2'd1,
        ST_FULL     = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
        logic [4:0]         rank;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [5:0]         count;
        logic signed [31:0] element;
    } t_rsp;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

// ===== design/sse_cell.sv =====
// One cell of the sorted chain: holds one element, compares it with the
// request value, and shifts toward or away from its neighbors. Uses sse_pkg.
module sse_cell
    import sse_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic signed [31:0] i_value,
    input  logic               i_occupied,
    input  logic signed [31:0] i_left_data,
    input  logic               i_left_lt,
    input  logic signed [31:0] i_right_data,
    output logic signed [31:0] o_data,
    output logic               o_lt,
    output logic               o_eq
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    assign o_lt   = i_occupied && (r_data < i_value);
    assign o_eq   = i_occupied && (r_data == i_value);
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins && !o_lt) begin
            n_data = i_left_lt ? i_value : i_left_data;
        end else if (i_ctl.del && !o_lt) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// ===== design/sorted_set_engine.sv =====
// Sorted set engine: keeps up to CAPACITY distinct signed 32-bit elements in
// ascending order. Each request word carries an operation (add, remove,
// member test, read at rank, clear), a value and a rank; each request gives
// exactly one response word with status, found flag, count and element.
// Both channels use valid and stall; a word moves at a clock edge where
// valid is high and stall is low.
// The elements live in a chain of cells that all compare against the request
// value at once; an accepted insert or delete shifts the chain by one place.
// The response enters the output register at the edge that accepts its
// request, and one request is taken every cycle while o_stall is low.
// The only thing that can slow the block is the receiver: while the
// response register is full and i_stall is high, o_stall is high and the
// response word holds.
// Synchronous reset empties the set and drops any pending response; the
// cell contents are not cleared, since entries beyond the count are never
// read.
// Depends on sse_pkg and sse_cell.
module sorted_set_engine
    import sse_pkg::*;
#(
    parameter int CAPACITY = SSE_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = (CW > 5) ? CW : 5;

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    t_rsp               r_rsp;
    t_rsp               n_rsp;
    logic               accept;
    logic               present;
    logic               full;
    logic               rank_ok;
    logic [RW-1:0]      rank_ext;
    logic [RW-1:0]      count_ext;
    logic [CW+5:0]      count_wide;
    logic signed [31:0] rank_data;
    t_cell_ctl          ctl;

    logic signed [31:0] data   [CAPACITY];
    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] eq;
    logic [CAPACITY-1:0] occupied;
    logic [CAPACITY-1:0] rank_hit;

    assign accept    = i_valid && !o_stall;
    assign o_stall   = r_out_valid && i_stall;
    assign o_valid   = r_out_valid;
    assign o_rsp     = r_rsp;
    assign present   = |eq;
    assign full      = (r_count == CW'(CAPACITY));
    assign rank_ext  = RW'(i_req.rank);
    assign count_ext = RW'(r_count);
    assign rank_ok   = rank_ext < count_ext;

    always_comb begin
        ctl.ins = accept && (i_req.req_type == OP_ADD) && !present && !full;
        ctl.del = accept && (i_req.req_type == OP_REMOVE) && present;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [31:0] left_data;
            logic               left_lt;
            logic signed [31:0] right_data;

            assign occupied[gi] = RW'(gi) < count_ext;
            assign rank_hit[gi] = rank_ext == RW'(gi);

            if (gi == 0) begin : g_first
                assign left_data = i_req.value;
                assign left_lt   = 1'b1;
            end else begin : g_mid
                assign left_data = data[gi-1];
                assign left_lt   = lt[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_data = data[gi];
            end else begin : g_inner
                assign right_data = data[gi+1];
            end

            sse_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_value      (i_req.value),
                .i_occupied   (occupied[gi]),
                .i_left_data  (left_data),
                .i_left_lt    (left_lt),
                .i_right_data (right_data),
                .o_data       (data[gi]),
                .o_lt         (lt[gi]),
                .o_eq         (eq[gi])
            );
        end
    endgenerate

    always_comb begin
        rank_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rank_data = rank_data | (rank_hit[k] ? data[k] : 32'sd0);
        end
    end

    always_comb begin
        n_count     = r_count;
        n_rsp       = '0;
        n_rsp.status = ST_NOCHANGE;
        case (i_req.req_type)
            OP_ADD: begin
                n_rsp.found = present;
                if (present) begin
                    n_rsp.status = ST_NOCHANGE;
                end else if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    n_rsp.status = ST_DONE;
                    n_count      = r_count + CW'(1);
                end
            end
            OP_REMOVE: begin
                n_rsp.found = present;
                if (present) begin
                    n_rsp.status = ST_DONE;
                    n_count      = r_count - CW'(1);
                end
            end
            OP_MEMBER: begin
                n_rsp.found  = present;
                n_rsp.status = ST_DONE;
            end
            OP_READ: begin
                if (rank_ok) begin
                    n_rsp.status  = ST_DONE;
                    n_rsp.element = rank_data;
                end else begin
                    n_rsp.status = ST_RANGE;
                end
            end
            OP_CLEAR: begin
                n_rsp.status = ST_DONE;
                n_count      = '0;
            end
            default: begin
                n_rsp.status = ST_NOCHANGE;
            end
        endcase
        count_wide  = {6'd0, n_count};
        n_rsp.count = count_wide[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

endmodule

// ===== design/sse_checker.sv =====
// Port-level checker for the sorted set engine, bound to the top level.
// Depends on sse_pkg and sorted_set_engine_macros.svh.
`include "sorted_set_engine_macros.svh"

module sse_checker
    import sse_pkg::*;
#(
    parameter int CAPACITY = SSE_CAPACITY
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_req i_req,
    input logic o_valid,
    input logic i_stall,
    input t_rsp o_rsp
);

    `SSE_ASSERT_NEXT(a_req_hold, i_valid && o_stall, i_valid && $stable(i_req))
    `SSE_ASSERT_NEXT(a_stall_hold, o_valid && i_stall, o_valid && $stable(o_rsp))
    `SSE_ASSERT_NOW(a_elem_only_read, o_valid && (o_rsp.element != 32'sd0), o_rsp.status == ST_DONE)
    `SSE_ASSERT_NOW(a_full_count, o_valid && (o_rsp.status == ST_FULL), o_rsp.count == 6'(CAPACITY))
    `SSE_ASSERT_NOW(a_found_status, o_valid && o_rsp.found, (o_rsp.status == ST_DONE) || (o_rsp.status == ST_NOCHANGE))

endmodule

bind sorted_set_engine sse_checker #(.CAPACITY(CAPACITY)) u_sse_checker (.*);

// ===== dv/tb_sorted_set_engine.sv =====
// Self-checking testbench for the sorted set engine: directed and random request words, with
// random idling on both channels, checked against a scoreboard that keeps its own sorted set.
// Depends on sse_pkg and sorted_set_engine.
module tb_sorted_set_engine;
    import sse_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int POOL_SIZE      = 40;
    localparam int BLOCKS         = 13;
    localparam int BLOCK_ITEMS    = 100;
    localparam int CALM_ITEMS     = 150;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    class set_scoreboard;
        logic signed [31:0] members [SSE_CAPACITY];
        int                 occupancy;
        t_rsp               awaited_rsps [$];
        int                 mismatches;
        int                 n_requests;
        int                 n_responses;
        int                 n_full;
        int                 n_read_hits;
        int                 peak;

        function new();
            foreach (members[i]) members[i] = '0;
            occupancy   = 0;
            mismatches  = 0;
            n_requests  = 0;
            n_responses = 0;
            n_full      = 0;
            n_read_hits = 0;
            peak        = 0;
        endfunction

        function t_rsp update_set(t_req r);
            t_rsp rsp;
            int   pos;
            int   i;
            bit   present;
            rsp        = '0;
            rsp.status = ST_NOCHANGE;
            pos        = 0;
            while (pos < occupancy && $signed(members[pos]) < $signed(r.value)) pos++;
            present = (pos < occupancy) && (members[pos] == r.value);
            case (r.req_type)
                OP_ADD: begin
                    rsp.found = present;
                    if (present) begin
                        rsp.status = ST_NOCHANGE;
                    end else if (occupancy >= SSE_CAPACITY) begin
                        rsp.status = ST_FULL;
                        n_full++;
                    end else begin
                        for (i = occupancy; i > pos; i--) members[i] = members[i - 1];
                        members[pos] = r.value;
                        occupancy++;
                        rsp.status = ST_DONE;
                    end
                end
                OP_REMOVE: begin
                    rsp.found = present;
                    if (present) begin
                        for (i = pos; i + 1 < occupancy; i++) members[i] = members[i + 1];
                        occupancy--;
                        rsp.status = ST_DONE;
                    end
                end
                OP_MEMBER: begin
                    rsp.found  = present;
                    rsp.status = ST_DONE;
                end
                OP_READ: begin
                    if (int'(r.rank) < occupancy) begin
                        rsp.element = members[r.rank];
                        rsp.status  = ST_DONE;
                        n_read_hits++;
                    end else begin
                        rsp.status = ST_RANGE;
                    end
                end
                OP_CLEAR: begin
                    occupancy  = 0;
                    rsp.status = ST_DONE;
                end
                default: rsp.status = ST_NOCHANGE;
            endcase
            if (occupancy > peak) peak = occupancy;
            rsp.count = 6'(occupancy);
            return rsp;
        endfunction

        function void note_request(t_req r);
            awaited_rsps.push_back(update_set(r));
            n_requests++;
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch in %s of response %0d: expected %0d, got %0d.",
                             field, n_responses, want, got);
            end
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            n_responses++;
            if (awaited_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Response word %0d arrived with none expected.", n_responses);
            end else begin
                want = awaited_rsps.pop_front();
                compare_field("status", want.status, got.status);
                compare_field("found", want.found, got.found);
                compare_field("count", want.count, got.count);
                compare_field("element", $signed(want.element), $signed(got.element));
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_req i_req   = '0;
    logic o_stall;
    logic o_valid;
    t_rsp o_rsp;

    set_scoreboard      sb;
    bit                 idling_on = 1'b1;
    bit                 stalling  = 1'b0;
    int                 stall_hold = 0;
    int                 quiet_cycles = 0;
    bit                 moved;
    logic signed [31:0] value_pool [POOL_SIZE];

    sorted_set_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!idling_on) begin
            stalling   = 1'b0;
            stall_hold = 0;
            i_stall <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            stalling   = !stalling;
            stall_hold = stalling ? $urandom_range(0, 6) : $urandom_range(0, 24);
            i_stall <= stalling;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_valid && !i_stall) begin
                sb.check_response(o_rsp);
                moved = 1'b1;
            end
            if (i_valid && !o_stall) begin
                sb.note_request(i_req);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("No word moved for %0d cycles.", WATCHDOG_LIMIT);
                $display("sorted_set_engine verification failed");
                $finish;
            end
        end
    end

    task automatic drive_word(t_req r);
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send(logic [2:0] op, logic signed [31:0] v, logic [4:0] rk);
        t_req r;
        r.req_type = op;
        r.value    = v;
        r.rank     = rk;
        drive_word(r);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.awaited_rsps.size() != 0) @(posedge i_clk);
    endtask

    task automatic refill_pool();
        foreach (value_pool[i]) begin
            case ($urandom_range(0, 11))
                0:       value_pool[i] = VAL_MIN;
                1:       value_pool[i] = VAL_MAX;
                2:       value_pool[i] = '0;
                3:       value_pool[i] = -32'sd1;
                default: value_pool[i] = $urandom;
            endcase
        end
    endtask

    function automatic t_req random_request(int add_weight);
        t_req r;
        int   pick;
        r.value = ($urandom_range(0, 99) < 85) ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : $urandom;
        if (sb.occupancy > 0 && $urandom_range(0, 9) < 6)
            r.rank = 5'($urandom_range(0, sb.occupancy - 1));
        else
            r.rank = 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < add_weight) begin
            r.req_type = OP_ADD;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      r.req_type = OP_REMOVE;
            else if (pick < 60) r.req_type = OP_MEMBER;
            else if (pick < 93) r.req_type = OP_READ;
            else if (pick < 97) r.req_type = OP_CLEAR;
            else                r.req_type = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        return r;
    endfunction

    initial begin
        int weight;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(OP_READ, 32'sd0, 5'd0);
        send(OP_REMOVE, 32'sd9, 5'd0);
        send(OP_MEMBER, 32'sd0, 5'd0);
        send(OP_ADD, 32'sd0, 5'd0);
        send(OP_ADD, VAL_MAX, 5'd31);
        send(OP_ADD, VAL_MIN, 5'd0);
        send(OP_ADD, -32'sd1, 5'd0);
        send(OP_ADD, 32'sd1, 5'd0);
        send(OP_ADD, 32'sd0, 5'd0);
        send(OP_MEMBER, VAL_MIN, 5'd0);
        send(OP_MEMBER, 32'sd5, 5'd0);
        send(OP_READ, 32'sd0, 5'd0);
        send(OP_READ, 32'sd0, 5'd4);
        send(OP_READ, 32'sd0, 5'd5);
        send(OP_READ, 32'sd0, 5'd31);
        send(OP_REMOVE, VAL_MAX, 5'd0);
        send(OP_REMOVE, 32'sd7, 5'd0);
        send(OP_SPARE_FIRST, $urandom, 5'd31);
        send(OP_SPARE_FIRST + 3'd1, $urandom, 5'd0);
        send(OP_SPARE_LAST, $urandom, 5'd17);
        send(OP_CLEAR, VAL_MAX, 5'd0);
        send(OP_READ, 32'sd0, 5'd0);
        drain_results();

        for (int blk = 0; blk < BLOCKS; blk++) begin
            refill_pool();
            case ($urandom_range(0, 2))
                0:       weight = 80;
                1:       weight = 45;
                default: weight = 20;
            endcase
            if (blk == 0) weight = 85;
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                if (blk * BLOCK_ITEMS + n == BLOCKS * BLOCK_ITEMS - CALM_ITEMS) idling_on = 1'b0;
                drive_word(random_request(weight));
            end
            if (blk == 0 || $urandom_range(0, 3) == 0) drain_results();
        end

        i_valid <= 1'b0;
        while (sb.awaited_rsps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Run covered %0d request words and %0d response words, peak count %0d,",
                 sb.n_requests, sb.n_responses, sb.peak);
        $display("%0d adds refused on a full set and %0d reads within range.",
                 sb.n_full, sb.n_read_hits);
        if (sb.mismatches == 0 && sb.awaited_rsps.size() == 0) begin
            $display("sorted_set_engine verification clean");
        end else begin
            $display("sorted_set_engine verification failed");
        end
        $finish;
    end

endmodule
